### rtl/ktss_pkg.sv
// Package for the k-th smallest threshold selector.
// Holds sizes, item structs, the cell link struct and the sequencer states.
// No dependencies.
package ktss_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int DIST_W      = 32;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int RC_W        = 7;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              last;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [DIST_W-1:0] threshold;
		logic              valid_res;
		logic              overflow;
		logic              end_of_run;
	} out_item_t;

	// what a sorted cell shows its right-hand neighbor
	typedef struct packed {
		logic              gt;
		logic [DIST_W-1:0] val;
	} link_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_THRESH,
		S_READ,
		S_CHECK,
		S_EMPTY
	} state_t;

endpackage

### rtl/ktss_cell.sv
// One insertion cell of the sorted chain.
// Depends on ktss_pkg (link_t, DIST_W).
module ktss_cell (
	input  logic                       clk,
	input  logic                       ins_en,
	input  logic                       occ,
	input  logic [ktss_pkg::DIST_W-1:0] din,
	input  ktss_pkg::link_t            left,
	output ktss_pkg::link_t            link
);

	logic [ktss_pkg::DIST_W-1:0] val_q;
	logic                        gt;

	assign gt        = occ && (val_q > din);
	assign link.gt   = gt;
	assign link.val  = val_q;

	// left neighbor larger: shift it in; else the new item lands here if we are
	// larger or empty. Unoccupied cells may pick up junk; it is never read.
	always_ff @(posedge clk) begin
		if (ins_en) begin
			if (left.gt) begin
				val_q <= left.val;
			end else if (gt || !occ) begin
				val_q <= din;
			end
		end
	end

endmodule

### rtl/ktss_store.sv
// Distance store in load order: one write port, one registered read port.
// Depends on ktss_pkg (sizes).
module ktss_store (
	input  logic                        clk,
	input  logic                        we,
	input  logic [ktss_pkg::IDX_W-1:0]  waddr,
	input  logic [ktss_pkg::DIST_W-1:0] wdata,
	input  logic [ktss_pkg::IDX_W-1:0]  raddr,
	output logic [ktss_pkg::DIST_W-1:0] rdata
);

	logic [ktss_pkg::DIST_W-1:0] mem [ktss_pkg::MAX_ENTRIES];
	logic [ktss_pkg::DIST_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/kth_smallest_threshold_select_top.sv
// Load: one distance item per cycle while idle, into a chain of insertion cells
// and the store. After the last item the threshold is picked from the chain, then
// each scanned entry: registered read, then compare and issue, plus stalls.
// Results leave through an output register. Reset clears count, overflow flag,
// sequencer and output valid; retain_count resets to 1. Stores need no clearing.
module kth_smallest_threshold_select_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ktss_pkg::in_item_t          in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ktss_pkg::out_item_t         out_data,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ktss_pkg::RC_W-1:0]   cfg_data
);

	localparam int N = ktss_pkg::MAX_ENTRIES;

	ktss_pkg::state_t state_q, state_d;

	logic [ktss_pkg::CNT_W-1:0]  cnt_q;
	logic                        ovf_q;
	logic [ktss_pkg::RC_W-1:0]   rc_q;
	logic [ktss_pkg::DIST_W-1:0] thr_q;
	logic [ktss_pkg::CNT_W-1:0]  total_q;
	logic [ktss_pkg::CNT_W-1:0]  kept_q;
	logic [ktss_pkg::IDX_W-1:0]  scan_q;
	logic                        out_valid_q;
	ktss_pkg::out_item_t         out_q;

	logic                        in_acc;
	logic                        store_ok;
	logic                        ins_en;
	logic                        slot_free;
	logic                        hit;
	logic                        last_hit;
	logic [ktss_pkg::DIST_W-1:0] rdata;
	logic [N-1:0]                occ;
	ktss_pkg::link_t             links [N];
	logic                        rc_lt;
	logic [ktss_pkg::IDX_W-1:0]  pos;
	logic [ktss_pkg::CNT_W-1:0]  total_d;

	// sequencer outputs
	logic emit;
	logic emit_valid;
	logic emit_eor;
	logic done;
	logic advance;

	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign store_ok  = cnt_q < ktss_pkg::CNT_W'(N);
	assign ins_en    = in_acc && store_ok;
	assign slot_free = !out_valid_q || out_ready;

	// sorted insertion chain
	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			ktss_pkg::link_t left;
			assign occ[g] = ktss_pkg::CNT_W'(g) < cnt_q;
			if (g == 0) begin : g_first
				assign left = '0;
			end else begin : g_rest
				assign left = links[g-1];
			end
			ktss_cell u_cell (
				.clk    (clk),
				.ins_en (ins_en),
				.occ    (occ[g]),
				.din    (in_data.distance),
				.left   (left),
				.link   (links[g])
			);
		end
	endgenerate

	ktss_store u_store (
		.clk   (clk),
		.we    (ins_en),
		.waddr (cnt_q[ktss_pkg::IDX_W-1:0]),
		.wdata (in_data.distance),
		.raddr (scan_q),
		.rdata (rdata)
	);

	// threshold position saturates to the largest entry; count >= 1 here
	assign rc_lt   = rc_q < cnt_q;
	assign pos     = rc_lt ? rc_q[ktss_pkg::IDX_W-1:0]
	                       : ktss_pkg::IDX_W'(cnt_q - ktss_pkg::CNT_W'(1));
	// entries <= threshold number at least pos+1, so the run emits min(rc, count)
	assign total_d = rc_lt ? ktss_pkg::CNT_W'(rc_q) : cnt_q;

	assign hit      = rdata <= thr_q;
	assign last_hit = (kept_q + ktss_pkg::CNT_W'(1)) == total_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ktss_pkg::S_IDLE: begin
				if (in_acc && in_data.last) begin
					state_d = ktss_pkg::S_THRESH;
				end
			end
			ktss_pkg::S_THRESH: begin
				state_d = (total_d == '0) ? ktss_pkg::S_EMPTY : ktss_pkg::S_READ;
			end
			ktss_pkg::S_READ: begin
				state_d = ktss_pkg::S_CHECK;
			end
			ktss_pkg::S_CHECK: begin
				if (!hit) begin
					state_d = ktss_pkg::S_READ;
				end else if (slot_free) begin
					state_d = last_hit ? ktss_pkg::S_IDLE : ktss_pkg::S_READ;
				end
			end
			ktss_pkg::S_EMPTY: begin
				if (slot_free) begin
					state_d = ktss_pkg::S_IDLE;
				end
			end
			default: state_d = ktss_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		emit       = 1'b0;
		emit_valid = 1'b0;
		emit_eor   = 1'b0;
		done       = 1'b0;
		advance    = 1'b0;
		case (state_q)
			ktss_pkg::S_IDLE: begin
				in_ready = 1'b1;
			end
			ktss_pkg::S_CHECK: begin
				if (!hit) begin
					advance = 1'b1;
				end else if (slot_free) begin
					emit       = 1'b1;
					emit_valid = 1'b1;
					emit_eor   = last_hit;
					done       = last_hit;
					advance    = 1'b1;
				end
			end
			ktss_pkg::S_EMPTY: begin
				if (slot_free) begin
					emit     = 1'b1;
					emit_eor = 1'b1;
					done     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ktss_pkg::S_IDLE;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			rc_q        <= ktss_pkg::RC_W'(1);
			total_q     <= '0;
			kept_q      <= '0;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				rc_q <= cfg_data;
			end
			if (ins_en) begin
				cnt_q <= cnt_q + ktss_pkg::CNT_W'(1);
			end else if (in_acc) begin
				ovf_q <= 1'b1;
			end
			if (state_q == ktss_pkg::S_THRESH) begin
				total_q <= total_d;
				kept_q  <= '0;
				scan_q  <= '0;
			end
			if (advance) begin
				scan_q <= scan_q + ktss_pkg::IDX_W'(1);
			end
			if (emit_valid) begin
				kept_q <= kept_q + ktss_pkg::CNT_W'(1);
			end
			if (done) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ktss_pkg::S_THRESH) begin
			thr_q <= links[pos].val;
		end
		if (emit) begin
			out_q.index      <= emit_valid ? scan_q : '0;
			out_q.threshold  <= thr_q;
			out_q.valid_res  <= emit_valid;
			out_q.overflow   <= ovf_q;
			out_q.end_of_run <= emit_eor;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ktss_pkg::CNT_W'(N))
		else $error("entry count above store depth");

	a_kept_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ktss_pkg::S_CHECK |-> kept_q < total_q)
		else $error("scan continued after all retained items were issued");

	a_empty_eor: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.valid_res |-> out_data.end_of_run)
		else $error("empty-run item without end of run");

	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> cnt_q == '0 && !ovf_q && state_q == ktss_pkg::S_IDLE)
		else $error("run end did not clear count and overflow");

endmodule

### tb/sv/threshold_select_checker.sv
// Checker for the k-th smallest threshold selector: watches the config, distance
// and result channels, predicts each run's retained indices and compares them.
// Depends on ktss_pkg.
module threshold_select_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      in_ready,
	input  ktss_pkg::in_item_t        in_data,
	input  logic                      out_valid,
	input  logic                      out_ready,
	input  ktss_pkg::out_item_t       out_data,
	input  logic                      cfg_valid,
	input  logic                      cfg_ready,
	input  logic [ktss_pkg::RC_W-1:0] cfg_data,
	output int                        fail_count,
	output int                        retained_left,
	output int                        results_seen
);

	logic [ktss_pkg::DIST_W-1:0] load_order [ktss_pkg::MAX_ENTRIES];
	logic [ktss_pkg::DIST_W-1:0] sorted_vals [ktss_pkg::MAX_ENTRIES];
	int unsigned                 held;
	bit                          dropped;
	logic [ktss_pkg::RC_W-1:0]   keep_count;
	ktss_pkg::out_item_t         retained_q [$];

	// store or drop a distance; on the last one pick the threshold and queue the run
	task automatic load_and_select(input ktss_pkg::in_item_t it);
		int unsigned                 pos;
		int unsigned                 i;
		int unsigned                 kept;
		logic [ktss_pkg::DIST_W-1:0] thr;
		ktss_pkg::out_item_t         r;
		if (held < ktss_pkg::MAX_ENTRIES) begin
			load_order[held] = it.distance;
			pos = held;
			while (pos > 0 && sorted_vals[pos-1] > it.distance) begin
				sorted_vals[pos] = sorted_vals[pos-1];
				pos--;
			end
			sorted_vals[pos] = it.distance;
			held++;
		end else begin
			dropped = 1'b1;
		end
		if (!it.last)
			return;
		thr = '0;
		if (held > 0)
			thr = (keep_count < held) ? sorted_vals[keep_count] : sorted_vals[held-1];
		kept = 0;
		for (i = 0; i < held && kept < keep_count; i++) begin
			if (load_order[i] <= thr) begin
				r.index      = ktss_pkg::IDX_W'(i);
				r.threshold  = thr;
				r.valid_res  = 1'b1;
				r.overflow   = dropped;
				r.end_of_run = 1'b0;
				retained_q   = {retained_q, r};
				kept++;
			end
		end
		if (kept == 0) begin
			r.index      = '0;
			r.threshold  = thr;
			r.valid_res  = 1'b0;
			r.overflow   = dropped;
			r.end_of_run = 1'b1;
			retained_q   = {retained_q, r};
		end else begin
			retained_q[retained_q.size()-1].end_of_run = 1'b1;
		end
		held    = 0;
		dropped = 1'b0;
	endtask

	task automatic check_field(input string name, input logic [ktss_pkg::DIST_W-1:0] want,
			input logic [ktss_pkg::DIST_W-1:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		ktss_pkg::out_item_t want;
		if (!arst_n) begin
			held       = 0;
			dropped    = 1'b0;
			keep_count = 7'd1;
			retained_q.delete();
			fail_count    = 0;
			retained_left = 0;
			results_seen  = 0;
		end else begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (retained_q.size() == 0) begin
					$error("unexpected result item: index %0d threshold %0h",
						out_data.index, out_data.threshold);
					fail_count++;
				end else begin
					want = retained_q.pop_front();
					check_field("index", ktss_pkg::DIST_W'(want.index),
						ktss_pkg::DIST_W'(out_data.index));
					check_field("threshold", want.threshold, out_data.threshold);
					check_field("valid_res", ktss_pkg::DIST_W'(want.valid_res),
						ktss_pkg::DIST_W'(out_data.valid_res));
					check_field("overflow", ktss_pkg::DIST_W'(want.overflow),
						ktss_pkg::DIST_W'(out_data.overflow));
					check_field("end_of_run", ktss_pkg::DIST_W'(want.end_of_run),
						ktss_pkg::DIST_W'(out_data.end_of_run));
				end
			end
			if (cfg_valid && cfg_ready)
				keep_count = cfg_data;
			if (in_valid && in_ready)
				load_and_select(in_data);
			retained_left = retained_q.size();
		end
	end

endmodule

### tb/sv/kth_smallest_threshold_select_top_test.sv
// Testbench top for kth_smallest_threshold_select_top: drives distance sets and
// retain_count writes, throttles the result side, and reports the verdict.
// Depends on ktss_pkg, the block and threshold_select_checker.
module kth_smallest_threshold_select_top_test;

	localparam int RANDOM_ITEMS  = 112;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES    = 20;
	localparam int OVERFLOW_SET  = 4;
	// worst quiet stretch: long receiver hold plus a full scan with no hits,
	// plus the longest gaps; taken well over ten times
	localparam int IDLE_LIMIT    = 5000;

	logic                      clk = 1'b0;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	ktss_pkg::in_item_t        in_data;
	logic                      out_valid;
	logic                      out_ready;
	ktss_pkg::out_item_t       out_data;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [ktss_pkg::RC_W-1:0] cfg_data;

	int fail_count;
	int retained_left;
	int results_seen;
	int idle_cycles;
	int sets_sent;
	int distances_sent;
	int settings_used;
	bit hold_req;

	kth_smallest_threshold_select_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	threshold_select_checker checker_i (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.retained_left (retained_left),
		.results_seen  (results_seen)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [ktss_pkg::DIST_W-1:0] pick_distance(input int style);
		case (style)
			0: return $urandom();
			1: return ktss_pkg::DIST_W'($urandom_range(0, 7));
			default: begin
				case ($urandom_range(0, 3))
					0: return '0;
					1: return '1;
					2: return {1'b1, {(ktss_pkg::DIST_W-1){1'b0}}};
					default: return ktss_pkg::DIST_W'($urandom_range(0, 255)) << 16;
				endcase
			end
		endcase
	endfunction

	function automatic logic [ktss_pkg::RC_W-1:0] pick_retain();
		case ($urandom_range(0, 6))
			0: return '0;
			1: return ktss_pkg::RC_W'(ktss_pkg::MAX_ENTRIES);
			2: return ktss_pkg::RC_W'(1);
			3: return ktss_pkg::RC_W'($urandom_range(0, ktss_pkg::MAX_ENTRIES));
			default: return ktss_pkg::RC_W'($urandom_range(0, 8));
		endcase
	endfunction

	// valid stays up across items when gap_after is 0
	task automatic send_distance(input logic [ktss_pkg::DIST_W-1:0] d, input bit lst,
			input int gap_after);
		ktss_pkg::in_item_t it;
		bit                 taken;
		it.distance = d;
		it.last     = lst;
		in_valid <= 1'b1;
		in_data  <= it;
		// ready is registered: its mid-cycle value holds at the next rising edge
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		distances_sent++;
		if (lst)
			sets_sent++;
		if (gap_after > 0) begin
			in_valid <= 1'b0;
			repeat (gap_after) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (retained_left != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_retain(input logic [ktss_pkg::RC_W-1:0] v);
		bit taken;
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end while (!taken);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	// result side: random stalls, long ready runs, one long hold on request
	initial begin
		int span;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				span = pick_gap();
				if (span > 0) begin
					out_ready <= 1'b0;
					repeat (span) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			span = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 4);
			repeat (span) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
		end
	end

	initial begin
		int  s;
		int  j;
		int  size;
		int  style;
		int  random_items;
		bit  calm;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		hold_req       = 1'b0;
		idle_cycles    = 0;
		sets_sent      = 0;
		distances_sent = 0;
		settings_used  = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// retain_count at its reset value of 1
		send_distance(32'hFFFF_FFFF, 1'b0, pick_gap());
		send_distance(32'h0000_0000, 1'b1, pick_gap());
		// one entry: position past the end saturates to it
		send_distance(32'h1234_5678, 1'b1, pick_gap());
		// nothing retained
		write_retain(ktss_pkg::RC_W'(0));
		send_distance(32'd5, 1'b0, pick_gap());
		send_distance(32'd3, 1'b1, pick_gap());
		// largest retain: threshold saturates, every index kept
		write_retain(ktss_pkg::RC_W'(ktss_pkg::MAX_ENTRIES));
		send_distance(32'd9, 1'b0, 0);
		send_distance(32'd2, 1'b0, 0);
		send_distance(32'd9, 1'b0, 0);
		send_distance(32'd0, 1'b1, pick_gap());
		// ties: all equal the threshold, emission stops at retain_count
		write_retain(ktss_pkg::RC_W'(2));
		for (j = 0; j < 4; j++)
			send_distance(32'd7, j == 3, pick_gap());
		write_retain(ktss_pkg::RC_W'(3));
		send_distance(32'hAAAA_AAAA, 1'b0, pick_gap());
		send_distance(32'h5555_5555, 1'b0, pick_gap());
		send_distance(32'hFFFF_0000, 1'b0, pick_gap());
		send_distance(32'h0000_FFFF, 1'b0, pick_gap());
		send_distance(32'h0000_0001, 1'b1, pick_gap());

		random_items = 0;
		s = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (s == OVERFLOW_SET)
				write_retain(ktss_pkg::RC_W'(ktss_pkg::MAX_ENTRIES));
			else if (s != OVERFLOW_SET + 1 && $urandom_range(0, 2) == 0)
				write_retain(pick_retain());
			// the overflow set fills the store; two more items, both dropped
			if (s == OVERFLOW_SET) begin
				size     = ktss_pkg::MAX_ENTRIES + 2;
				hold_req = 1'b1;
			end else if ($urandom_range(0, 9) == 0) begin
				size = $urandom_range(9, 20);
			end else begin
				size = $urandom_range(1, 6);
			end
			style = $urandom_range(0, 2);
			// overflow set goes back to back so its scan meets the receiver hold
			calm  = (s == OVERFLOW_SET) || ($urandom_range(0, 3) == 0);
			for (j = 0; j < size; j++)
				send_distance(pick_distance(style), j == size - 1, calm ? 0 : pick_gap());
			random_items += size;
			s++;
		end

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		$display("Covered %0d distance sets (%0d distances) under %0d retain settings.",
			sets_sent, distances_sent, settings_used);
		$display("Compared %0d result items, including a full store with dropped items.",
			results_seen);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
